/* hdl/sdd_pkg.sv */
// Shared types, constants and the fractional power table for the soft
// Damerau-Levenshtein scorer. Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package sdd_pkg;

  localparam int MW      = 34;           // operand width of the shared multiplier
  localparam int LENW    = 7;            // length register width
  localparam int CFGW    = 31;           // widest configuration register
  localparam int CFG_AW  = 3;            // configuration index width
  localparam int EXP_LIMIT = 88;         // exp argument floor, in whole units
  localparam int WCUT    = 89;           // difference cutoff, in temperatures

  localparam logic [32:0] LOG2E_Q32 = 33'd6196328018;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;

  typedef enum logic [CFG_AW-1:0] {
    CFG_LEN_A = 3'd0,
    CFG_LEN_B = 3'd1,
    CFG_INS   = 3'd2,
    CFG_DEL   = 3'd3,
    CFG_SWAP  = 3'd4,
    CFG_TEMP  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] sub_cost;
    logic signed [7:0]  trans_row;
    logic signed [7:0]  trans_col;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] score;
    logic               saturated;
  } out_beat_t;

  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_MEM  = 2'd1,
    SRC_MUL  = 2'd2
  } src_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_RDW, S_T1, S_T1W, S_T2, S_T2W,
    S_WD, S_WDIV, S_WU, S_WUW, S_WP, S_WPW, S_WSH,
    S_LG0, S_LGM, S_LGW, S_LN, S_LNW, S_TL, S_TLW, S_FIN
  } state_t;

  typedef logic [31:0] pow_tab_t [0:32];

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bt;
    n   = n_in;
    res = '0;
    for (int s = 31; s >= 0; s--) begin
      bt = 64'd1 << (2 * s);
      if (n >= res + bt) begin
        n   = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // Entry b holds 2^(-2^-b) in Q32, each the floor root of the one before.
  function automatic pow_tab_t pow_table();
    pow_tab_t    tab;
    logic [63:0] prev;
    prev   = 64'd1 << 31;
    tab[0] = 32'h8000_0000;
    for (int b = 1; b <= 32; b++) begin
      prev   = isqrt64(prev << 32);
      tab[b] = prev[31:0];
    end
    return tab;
  endfunction

  localparam pow_tab_t POW_TAB = pow_table();

endpackage

/* hdl/sdd_mul.sv */
// Shared unsigned multiplier with a registered product.
// Depends on sdd_pkg for the operand width.
`timescale 1ns / 1ps

module sdd_mul
  import sdd_pkg::*;
(
  input  logic              clk,
  input  logic [MW-1:0]     mul_a,
  input  logic [MW-1:0]     mul_b,
  output logic [2*MW-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

endmodule

/* hdl/sdd_div.sv */
// Restoring divider, one quotient bit per cycle, 31-bit divisor.
// Depends on sdd_pkg; the caller guarantees the quotient fits in QW bits.
`timescale 1ns / 1ps

module sdd_div
  import sdd_pkg::*;
#(
  parameter int QW = 23
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [QW+30:0]   num,
  input  logic [30:0]      den,
  output logic             done,
  output logic [QW-1:0]    quo
);

  localparam int CNTW = $clog2(QW + 1);

  logic [30:0]     rem_r;
  logic [QW-1:0]   low_r;
  logic [QW-1:0]   quo_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [31:0]     trial;
  logic            fits;

  assign trial = {rem_r, low_r[QW-1]};
  assign fits  = trial >= {1'b0, den};
  assign done  = done_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[QW+30:QW];
      low_r <= num[QW-1:0];
    end else if (busy_r) begin
      rem_r <= fits ? 31'(trial - {1'b0, den}) : trial[30:0];
      low_r <= low_r << 1;
      quo_r <= {quo_r[QW-2:0], fits};
    end
  end

endmodule

/* hdl/soft_damerau_edit_distance_top.sv */
// Top level of the soft Damerau-Levenshtein scorer: sequencer, alpha store,
// configuration registers. Depends on sdd_pkg, sdd_mul and sdd_div.
`timescale 1ns / 1ps
//
//  channel | ports                         | beat
//  --------+-------------------------------+------------------------------------
//  input   | in_valid  in_ready  in_data   | one table entry: sub cost, swap src
//  output  | out_valid out_ready out_data  | score and saturation flag, last entry
//  config  | cfg_we    cfg_addr  cfg_wdata | one register write, no handshake
//
//  An entry works through the one shared multiplier in turn: each valid
//  candidate within the cutoff runs a serial divide and up to 32 table products,
//  and the log takes 32 squarings. The input is ready only while the sequencer
//  idles.
//  Synchronous active-low reset clears control, position and registers; the
//  alpha store needs no clearing. A result held by out_ready stalls the
//  sequencer only at the last entry of a pair.

module soft_damerau_edit_distance_top
  import sdd_pkg::*;
#(
  parameter int MAX_LEN   = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_beat_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_beat_t           out_data,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFGW-1:0]     cfg_wdata
);

  localparam int LW    = $clog2(MAX_LEN);
  localparam int PW    = $clog2(MAX_LEN + 1);
  localparam int CW    = LW + 34;           // candidate width, signed
  localparam int WIDE  = (CW > 38) ? CW : 38;
  localparam int QW    = FRAC_BITS + 7;     // quotient width of the divide
  localparam int AW    = 2 * LW;
  localparam int DEPTH = 1 << AW;
  localparam int LNW   = FRAC_BITS + 3;
  localparam int VW    = CW + 2;

  localparam logic [QW-1:0]        ZCAP = QW'(EXP_LIMIT) << FRAC_BITS;
  localparam logic signed [VW-1:0] SMAX = VW'(64'sd2147483647);
  localparam logic signed [VW-1:0] SMIN = VW'(-64'sd2147483648);

  // configuration registers
  logic [LENW-1:0] len_a_r, len_b_r;
  logic [30:0]     ins_r, del_r, swap_r, temp_r;

  // control
  state_t          state_r, state_nxt;
  logic [PW-1:0]   cell_row_r, cell_col_r;
  logic            sat_seen_r;
  logic            out_valid_r;
  out_beat_t       out_data_r;

  // per-entry datapath
  logic signed [31:0]    sub_r;
  logic [PW-1:0]         tr_r, tc_r;
  logic                  vld3_r;
  logic [1:0]            k_r;
  src_t                  src_r;
  logic signed [CW-1:0]  cand_r [4];
  logic signed [CW-1:0]  m_r;
  logic                  satc_r;
  logic [6:0]            n_r;
  logic [31:0]           f_r;
  logic [32:0]           w_r;
  logic [5:0]            b_r;
  logic [34:0]           s_r;
  logic [1:0]            e_r;
  logic [31:0]           x_r;
  logic [31:0]           bits_r;
  logic [LNW-1:0]        ln_r;
  logic signed [31:0]    val_r;

  // alpha store
  logic [31:0]           mem [DEPTH];
  logic [31:0]           rdata_r;
  logic [AW-1:0]         rd_addr, wr_addr;

  // shared units
  logic [MW-1:0]         mul_a, mul_b;
  logic [2*MW-1:0]       prod;
  logic                  div_start, div_done;
  logic [QW-1:0]         div_quo;
  logic [QW+30:0]        div_num;

  // combinational helpers
  logic [PW-1:0]         la, lb;
  logic [30:0]           t_eff;
  logic [37:0]           t89;
  logic [PW-1:0]         rr, cc, rr_m1, cc_m1;
  logic                  accept;
  logic                  edge_over;
  logic signed [CW-1:0]  base_w, addend_w, cand_new, cand3_fin;
  logic [CW-1:0]         d_w;
  logic [WIDE-1:0]       d_ext;
  logic                  vld_k, d_over, wd_go, z_over, fbit;
  logic [5:0]            fsub;
  logic [32:0]           sq;
  logic [33:0]           q_w;
  logic signed [VW-1:0]  diff_w;
  logic                  fin_last, slot_free, leave;

  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Clamp lengths into 1..MAX_LEN and the temperature to at least one LSB.
  assign la    = (len_a_r == '0) ? PW'(1) :
                 ((32'(len_a_r) > MAX_LEN) ? PW'(MAX_LEN) : PW'(len_a_r));
  assign lb    = (len_b_r == '0) ? PW'(1) :
                 ((32'(len_b_r) > MAX_LEN) ? PW'(MAX_LEN) : PW'(len_b_r));
  assign t_eff = (temp_r == '0) ? 31'd1 : temp_r;
  assign t89   = 38'(t_eff) * 38'(WCUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_a_r <= LENW'(1);
      len_b_r <= LENW'(1);
      ins_r   <= 31'd65536;
      del_r   <= 31'd65536;
      swap_r  <= 31'd65536;
      temp_r  <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_LEN_A: len_a_r <= cfg_wdata[LENW-1:0];
        CFG_LEN_B: len_b_r <= cfg_wdata[LENW-1:0];
        CFG_INS:   ins_r   <= cfg_wdata;
        CFG_DEL:   del_r   <= cfg_wdata;
        CFG_SWAP:  swap_r  <= cfg_wdata;
        CFG_TEMP:  temp_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Neighbor picked by the candidate counter: diagonal, up, left, swap source.
  always_comb begin
    case (k_r)
      2'd0: begin
        rr = cell_row_r - PW'(1);
        cc = cell_col_r - PW'(1);
      end
      2'd1: begin
        rr = cell_row_r - PW'(1);
        cc = cell_col_r;
      end
      2'd2: begin
        rr = cell_row_r;
        cc = cell_col_r - PW'(1);
      end
      default: begin
        rr = tr_r;
        cc = tc_r;
      end
    endcase
  end

  assign rr_m1   = rr - PW'(1);
  assign cc_m1   = cc - PW'(1);
  assign rd_addr = {rr_m1[LW-1:0], cc_m1[LW-1:0]};
  assign wr_addr = {rr_m1[LW-1:0] & '0 | LW'(cell_row_r - PW'(1)),
                    LW'(cell_col_r - PW'(1))};

  // Base value of the neighbor read: store word, saturated edge product, zero.
  assign edge_over = |prod[2*MW-1:31];
  always_comb begin
    case (src_r)
      SRC_MEM: base_w = {{(CW-32){rdata_r[31]}}, rdata_r};
      SRC_MUL: base_w = edge_over ? CW'(32'h7fff_ffff) : {{(CW-31){1'b0}}, prod[30:0]};
      default: base_w = '0;
    endcase
  end

  always_comb begin
    case (k_r)
      2'd0:    addend_w = {{(CW-32){sub_r[31]}}, sub_r};
      2'd1:    addend_w = {{(CW-31){1'b0}}, del_r};
      2'd2:    addend_w = {{(CW-31){1'b0}}, ins_r};
      default: addend_w = {{(CW-31){1'b0}}, swap_r};
    endcase
  end

  assign cand_new  = base_w + addend_w;
  assign cand3_fin = cand_r[3] + CW'(prod);

  // Weight stage helpers.
  assign d_w     = cand_r[k_r] - m_r;
  assign d_ext   = WIDE'(d_w);
  assign vld_k   = (k_r != 2'd3) || vld3_r;
  assign d_over  = d_ext > WIDE'(t89);
  assign wd_go   = vld_k && !d_over;
  assign div_num = {d_ext[37:0], {FRAC_BITS{1'b0}}};
  assign z_over  = div_quo > ZCAP;
  assign fsub    = 6'd32 - b_r;
  assign fbit    = f_r[fsub[4:0]];
  assign sq      = prod[63:31];
  assign q_w     = prod[FRAC_BITS +: 34];
  assign diff_w  = VW'(m_r) - $signed({{(VW-34){1'b0}}, q_w});

  assign fin_last  = (cell_row_r >= la) && (cell_col_r >= lb);
  assign slot_free = !out_valid_r || out_ready;
  assign leave     = !fin_last || slot_free;

  sdd_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  sdd_div #(.QW(QW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (t_eff),
    .done  (div_done),
    .quo   (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RD;
      S_RD:   state_nxt = S_RDW;
      S_RDW: begin
        if (k_r == 2'd3)                state_nxt = S_T1;
        else if (k_r == 2'd2 && !vld3_r) state_nxt = S_WD;
        else                            state_nxt = S_RD;
      end
      S_T1:  state_nxt = S_T1W;
      S_T1W: state_nxt = S_T2;
      S_T2:  state_nxt = S_T2W;
      S_T2W: state_nxt = S_WD;
      S_WD: begin
        if (wd_go)            state_nxt = S_WDIV;
        else if (k_r == 2'd3) state_nxt = S_LG0;
      end
      S_WDIV: begin
        if (div_done) begin
          if (!z_over)          state_nxt = S_WU;
          else if (k_r == 2'd3) state_nxt = S_LG0;
          else                  state_nxt = S_WD;
        end
      end
      S_WU:  state_nxt = S_WUW;
      S_WUW: state_nxt = S_WP;
      S_WP: begin
        if (fbit)               state_nxt = S_WPW;
        else if (b_r == 6'd32)  state_nxt = S_WSH;
      end
      S_WPW: state_nxt = (b_r == 6'd32) ? S_WSH : S_WP;
      S_WSH: state_nxt = (k_r == 2'd3) ? S_LG0 : S_WD;
      S_LG0: state_nxt = S_LGM;
      S_LGM: state_nxt = S_LGW;
      S_LGW: state_nxt = (b_r == 6'd31) ? S_LN : S_LGM;
      S_LN:  state_nxt = S_LNW;
      S_LNW: state_nxt = S_TL;
      S_TL:  state_nxt = S_TLW;
      S_TLW: state_nxt = S_FIN;
      S_FIN: if (leave) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // unit operands and handshake outputs
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_RD: begin
        if (cc == '0 && rr != '0) begin
          mul_a = MW'(rr);
          mul_b = MW'(del_r);
        end else if (rr == '0 && cc != '0) begin
          mul_a = MW'(cc);
          mul_b = MW'(ins_r);
        end
      end
      S_T1: begin
        mul_a = MW'(cell_row_r - tr_r - PW'(1));
        mul_b = MW'(del_r);
      end
      S_T2: begin
        mul_a = MW'(cell_col_r - tc_r - PW'(1));
        mul_b = MW'(ins_r);
      end
      S_WD:  div_start = wd_go;
      S_WU: begin
        mul_a = MW'(div_quo);
        mul_b = MW'(LOG2E_Q32);
      end
      S_WP: begin
        mul_a = MW'(w_r);
        mul_b = MW'(POW_TAB[b_r]);
      end
      S_LGM: begin
        mul_a = MW'(x_r);
        mul_b = MW'(x_r);
      end
      S_LN: begin
        mul_a = {e_r, bits_r};
        mul_b = MW'(LN2_Q30);
      end
      S_TL: begin
        mul_a = MW'(t_eff);
        mul_b = MW'(ln_r);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cell_row_r  <= PW'(1);
      cell_col_r  <= PW'(1);
      sat_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (state_r == S_FIN && leave) begin
        if (fin_last) begin
          out_valid_r <= 1'b1;
          cell_row_r  <= PW'(1);
          cell_col_r  <= PW'(1);
          sat_seen_r  <= 1'b0;
        end else begin
          sat_seen_r <= sat_seen_r | satc_r;
          if (cell_col_r >= lb) begin
            cell_col_r <= PW'(1);
            cell_row_r <= cell_row_r + PW'(1);
          end else begin
            cell_col_r <= cell_col_r + PW'(1);
          end
        end
      end
    end
  end

  // result beat; write it once the slot is free
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && fin_last && slot_free) begin
      out_data_r.score     <= val_r;
      out_data_r.saturated <= sat_seen_r | satc_r;
    end
  end

  // alpha store: one read port registered every cycle, one write port
  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (state_r == S_FIN && leave) mem[wr_addr] <= val_r;
  end

  // per-entry datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          sub_r  <= in_data.sub_cost;
          tr_r   <= PW'(in_data.trans_row[6:0]);
          tc_r   <= PW'(in_data.trans_col[6:0]);
          vld3_r <= !in_data.trans_row[7] && !in_data.trans_col[7] &&
                    (32'(in_data.trans_row[6:0]) < 32'(cell_row_r)) &&
                    (32'(in_data.trans_col[6:0]) < 32'(cell_col_r));
          k_r    <= 2'd0;
          satc_r <= 1'b0;
        end
      end
      S_RD: begin
        if (rr != '0 && cc != '0)      src_r <= SRC_MEM;
        else if (rr == '0 && cc == '0) src_r <= SRC_ZERO;
        else                           src_r <= SRC_MUL;
      end
      S_RDW: begin
        cand_r[k_r] <= cand_new;
        if (src_r == SRC_MUL && edge_over) satc_r <= 1'b1;
        if (k_r != 2'd3 && (k_r == 2'd0 || cand_new < m_r)) m_r <= cand_new;
        if (k_r == 2'd2 && !vld3_r) begin
          k_r <= 2'd0;
          s_r <= '0;
        end else if (k_r != 2'd3) begin
          k_r <= k_r + 2'd1;
        end
      end
      S_T1W: cand_r[3] <= cand3_fin;
      S_T2W: begin
        cand_r[3] <= cand3_fin;
        if (cand3_fin < m_r) m_r <= cand3_fin;
        k_r <= 2'd0;
        s_r <= '0;
      end
      S_WD:   if (!wd_go) k_r <= k_r + 2'd1;
      S_WDIV: if (div_done && z_over) k_r <= k_r + 2'd1;
      S_WUW: begin
        n_r <= prod[FRAC_BITS+32 +: 7];
        f_r <= prod[FRAC_BITS +: 32];
        w_r <= 33'h1_0000_0000;
        b_r <= 6'd1;
      end
      S_WP:  if (!fbit) b_r <= b_r + 6'd1;
      S_WPW: begin
        w_r <= prod[64:32];
        b_r <= b_r + 6'd1;
      end
      S_WSH: begin
        s_r <= s_r + 35'(w_r >> n_r);
        k_r <= k_r + 2'd1;
      end
      S_LG0: begin
        if (s_r[34]) begin
          e_r <= 2'd2;
          x_r <= s_r[34:3];
        end else if (s_r[33]) begin
          e_r <= 2'd1;
          x_r <= s_r[33:2];
        end else begin
          e_r <= 2'd0;
          x_r <= s_r[32:1];
        end
        bits_r <= '0;
        b_r    <= '0;
      end
      S_LGW: begin
        bits_r <= {bits_r[30:0], sq[32]};
        x_r    <= sq[32] ? sq[32:1] : sq[31:0];
        b_r    <= b_r + 6'd1;
      end
      S_LNW: ln_r <= prod[62-FRAC_BITS +: LNW];
      S_TLW: begin
        if (diff_w > SMAX) begin
          val_r  <= 32'sh7fff_ffff;
          satc_r <= 1'b1;
        end else if (diff_w < SMIN) begin
          val_r  <= 32'sh8000_0000;
          satc_r <= 1'b1;
        end else begin
          val_r <= diff_w[31:0];
        end
      end
      default: ;
    endcase
  end

  // A result beat appears only out of the write-back step.
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result beat raised outside write-back");

  // An accepted beat starts the neighbor reads on the next cycle.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_RD)
    else $error("accepted beat did not start the sequencer");

  // The divider only finishes while the sequencer waits on it.
  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_WDIV)
    else $error("divider finished outside its wait state");

  // The least candidate always weighs one, so the sum is at least one.
  a_sum_floor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LG0 |-> s_r[34:32] != 3'd0)
    else $error("weight sum below one");

endmodule

/* verif/tb_soft_damerau_edit_distance_top.sv */
// Self-checking testbench for the soft Damerau-Levenshtein scorer top level.
// Depends on sdd_pkg and the RTL under hdl/; holds its own fixed-point predictor.
`timescale 1ns / 1ps

module tb_soft_damerau_edit_distance_top;
  import sdd_pkg::*;

  localparam int    ALEN      = 64;          // table side of the block
  localparam int    RANDOM_N  = 550;         // random cells to send
  localparam int    SETTLE    = 600;         // cycles for one cell to work through
  localparam longint ONE_Q16  = 65536;
  localparam logic [30:0] CMAX = 31'h7FFF_FFFF;

  typedef logic [5:0][30:0] cfg_set_t;       // index order of cfg_idx_t

  // One directed row: register set, cell beat and, where obvious, the score.
  typedef struct {
    cfg_set_t  regs;
    in_beat_t  beat;
    bit        typed;
    out_beat_t score;
  } cell_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  logic      cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFGW-1:0]   cfg_wdata;

  soft_damerau_edit_distance_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the registers, position and alpha table.
  // ---------------------------------------------------------------------------
  logic signed [31:0] alpha_mem [0:ALEN*ALEN-1];
  int unsigned        at_row, at_col;
  bit                 pair_sat;
  longint             rows_reg, cols_reg, ins_reg, del_reg, swap_reg, temp_reg;
  longint unsigned    pow_q32 [0:32];     // 2^(-2^-b) in Q32

  out_beat_t expected_scores [$];
  cell_row_t directed_rows [$];
  cfg_set_t  cur_regs;
  int        errors;
  int        cells_sent;
  int        scores_checked;
  int        reg_writes;
  bit        quiet;                        // no idling in the tail of the run

  function automatic longint unsigned root64(longint unsigned n_in);
    longint unsigned n, res, bt;
    n   = n_in;
    res = 0;
    bt  = 64'd1 << 62;
    while (bt > n) bt >>= 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n   = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp_len(longint v);
    return v == 0 ? 1 : (v > ALEN ? ALEN : v);
  endfunction

  // Row 0 and column 0 are multiples of a cost; clip to the 32-bit top.
  function automatic longint edge_val(longint k, longint cost, inout bit sat);
    longint unsigned v;
    v = longint'(k) * longint'(cost);
    if (v > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 64'h7FFF_FFFF;
    end
    return longint'(v);
  endfunction

  function automatic longint alpha_at(int unsigned r, int unsigned c, inout bit sat);
    if (r == 0 && c == 0) return 0;
    if (c == 0) return edge_val(r, del_reg, sat);
    if (r == 0) return edge_val(c, ins_reg, sat);
    return longint'(alpha_mem[((r - 1) % ALEN) * ALEN + ((c - 1) % ALEN)]);
  endfunction

  // exp(-d/T) in Q32 from the fractional power table; zero past the cutoffs.
  function automatic longint unsigned exp_weight(longint unsigned d, longint unsigned t);
    longint unsigned z, u, f, n, w;
    w = 64'd1 << 32;
    if (d > 89 * t) return 0;
    z = (d << 16) / t;
    if (z > (64'd88 << 16)) return 0;
    u = (z * 64'd6196328018) >> 16;
    n = u >> 32;
    f = u & 64'hFFFF_FFFF;
    for (int b = 1; b <= 32; b++)
      if ((f >> (32 - b)) & 1) w = (w * pow_q32[b]) >> 32;
    return n >= 64 ? 0 : (w >> n);
  endfunction

  // Natural log of a Q32 sum (>= 1.0), result in Q16.
  function automatic longint unsigned ln_q16(longint unsigned s);
    longint unsigned e, x, bits, lg;
    e    = 0;
    bits = 0;
    if (s >= (64'd1 << 34)) e = 2;
    else if (s >= (64'd1 << 33)) e = 1;
    x = s >> (e + 1);
    for (int b = 0; b < 32; b++) begin
      x = (x * x) >> 31;
      bits <<= 1;
      if (x >= (64'd1 << 32)) begin
        bits |= 1;
        x >>= 1;
      end
    end
    lg = (e << 32) | bits;
    return (lg * 64'd744261118) >> 46;
  endfunction

  // Score one cell at the current position; flag and fill a result at the last one.
  function automatic bit score_cell(input in_beat_t b, output out_beat_t r);
    int unsigned     i, j;
    longint          la, lb, tr, tc, m, val;
    longint unsigned t, s;
    longint          cand [4];
    bit              ok [4];
    bit              sat;
    i   = at_row;
    j   = at_col;
    la  = clamp_len(rows_reg);
    lb  = clamp_len(cols_reg);
    t   = temp_reg == 0 ? 1 : temp_reg;
    tr  = longint'(b.trans_row);
    tc  = longint'(b.trans_col);
    sat = 1'b0;
    s   = 0;
    r   = '0;
    ok  = '{1'b1, 1'b1, 1'b1, 1'b0};
    cand[0] = alpha_at(i - 1, j - 1, sat) + longint'(b.sub_cost);
    cand[1] = alpha_at(i - 1, j, sat) + del_reg;
    cand[2] = alpha_at(i, j - 1, sat) + ins_reg;
    cand[3] = 0;
    if (tr >= 0 && tc >= 0 && tr < i && tc < j) begin
      ok[3]   = 1'b1;
      cand[3] = alpha_at(tr, tc, sat) + swap_reg
              + (longint'(i) - tr - 1) * del_reg + (longint'(j) - tc - 1) * ins_reg;
    end
    m = cand[0];
    for (int k = 1; k < 4; k++)
      if (ok[k] && cand[k] < m) m = cand[k];
    for (int k = 0; k < 4; k++)
      if (ok[k]) s += exp_weight(longint'(cand[k] - m), t);
    val = m - longint'((t * ln_q16(s)) >> 16);
    if (val > 64'sh7FFF_FFFF) begin
      val = 64'sh7FFF_FFFF;
      sat = 1'b1;
    end
    if (val < -64'sh8000_0000) begin
      val = -64'sh8000_0000;
      sat = 1'b1;
    end
    alpha_mem[((i - 1) % ALEN) * ALEN + ((j - 1) % ALEN)] = val[31:0];
    if (sat) pair_sat = 1'b1;
    if (i >= la && j >= lb) begin
      r.score     = val[31:0];
      r.saturated = pair_sat;
      at_row      = 1;
      at_col      = 1;
      pair_sat    = 1'b0;
      return 1'b1;
    end
    if (j >= lb) begin
      at_col = 1;
      at_row = i + 1;
    end else begin
      at_col = j + 1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, mismatch reporting and the result checker.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
             scores_checked);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_scores.size() == 0) begin
        report("unexpected score beat", out_data.score, 0);
      end else begin
        out_beat_t want;
        want = expected_scores.pop_front();
        if (out_data.score !== want.score)
          report("score", longint'(out_data.score), longint'(want.score));
        if (out_data.saturated !== want.saturated)
          report("saturated", out_data.saturated, want.saturated);
      end
      scores_checked++;
    end
  end

  // Receiver back-pressure: random stall bursts, none once the tail starts.
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 12);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Drive one cell beat, hold it until accepted, then score it.
  task automatic send_cell(input in_beat_t b);
    out_beat_t r;
    in_data <= b;
    if (!in_valid) in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    cells_sent++;
    if (score_cell(b, r)) expected_scores.push_back(r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Drop valid, wait out every pending score and the cell still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all six registers, one per edge, and mirror them in the predictor.
  task automatic load_regs(input cfg_set_t regs);
    for (int k = 0; k < 6; k++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= k[CFG_AW-1:0];
      cfg_wdata <= regs[k];
      @(posedge clk);
      reg_writes++;
      case (cfg_idx_t'(k))
        CFG_LEN_A: rows_reg = regs[k] & 31'h7F;
        CFG_LEN_B: cols_reg = regs[k] & 31'h7F;
        CFG_INS:   ins_reg  = regs[k];
        CFG_DEL:   del_reg  = regs[k];
        CFG_SWAP:  swap_reg = regs[k];
        CFG_TEMP:  temp_reg = regs[k];
        default: ;
      endcase
    end
    cfg_we   <= 1'b0;
    cur_regs = regs;
  endtask

  function automatic cfg_set_t make_regs(longint la, longint lb, longint ins,
                                         longint del, longint swp, longint temp);
    cfg_set_t c;
    c[CFG_LEN_A] = la;
    c[CFG_LEN_B] = lb;
    c[CFG_INS]   = ins;
    c[CFG_DEL]   = del;
    c[CFG_SWAP]  = swp;
    c[CFG_TEMP]  = temp;
    return c;
  endfunction

  function automatic void add_row(input cfg_set_t regs, input logic [31:0] sub,
                                  input logic [7:0] tr, input logic [7:0] tc,
                                  input bit typed, input logic [31:0] score,
                                  input bit sat);
    cell_row_t row;
    row.regs            = regs;
    row.beat.sub_cost   = sub;
    row.beat.trans_row  = tr;
    row.beat.trans_col  = tc;
    row.typed           = typed;
    row.score.score     = score;
    row.score.saturated = sat;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [30:0] pick_cost();
    case ($urandom_range(0, 7))
      0:       return 31'd0;
      1:       return CMAX;
      2:       return $urandom;
      default: return $urandom_range(0, 3 * ONE_Q16);
    endcase
  endfunction

  function automatic logic [30:0] pick_temp();
    case ($urandom_range(0, 9))
      0:       return 31'd0;
      1:       return 31'd1;
      2:       return CMAX;
      3:       return $urandom;
      default: return $urandom_range(ONE_Q16 / 8, 4 * ONE_Q16);
    endcase
  endfunction

  // Random cell at (i,j): mostly a legal swap source, some none or any byte.
  function automatic in_beat_t random_cell(int unsigned i, int unsigned j);
    in_beat_t b;
    case ($urandom_range(0, 9))
      0:       b.sub_cost = $urandom;
      1:       b.sub_cost = 32'h8000_0000;
      2:       b.sub_cost = 32'h7FFF_FFFF;
      default: b.sub_cost = $urandom_range(0, 4 * ONE_Q16) - 2 * ONE_Q16;
    endcase
    case ($urandom_range(0, 9))
      0: begin
        b.trans_row = 8'hFF;
        b.trans_col = 8'hFF;
      end
      1: begin
        b.trans_row = $urandom;
        b.trans_col = $urandom;
      end
      default: begin
        b.trans_row = $urandom_range(0, i - 1);
        b.trans_col = $urandom_range(0, j - 1);
      end
    endcase
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    cfg_set_t dflt, wide, regs;
    cell_row_t row;
    int        la, lb, npairs;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b1;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    errors         = 0;
    cells_sent     = 0;
    scores_checked = 0;
    reg_writes     = 0;
    quiet          = 1'b0;

    pow_q32[0] = 64'd1 << 31;
    for (int b = 1; b <= 32; b++) pow_q32[b] = root64(pow_q32[b - 1] << 32);
    at_row   = 1;
    at_col   = 1;
    pair_sat = 1'b0;
    rows_reg = 1;
    cols_reg = 1;
    ins_reg  = ONE_Q16;
    del_reg  = ONE_Q16;
    swap_reg = ONE_Q16;
    temp_reg = ONE_Q16;
    dflt     = make_regs(1, 1, ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16);
    cur_regs = dflt;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows. Reset registers first: a huge negative substitution wins
    // outright; a huge positive one leaves two equal candidates, so ln 2.
    add_row(dflt, 32'h8000_0000, 8'hFF, 8'hFF, 1, 32'h8000_0000, 0);
    add_row(dflt, 32'h7FFF_FFFF, 8'hFF, 8'hFF, 1, 32'd85646, 0);
    add_row(dflt, 32'd0, 8'd0, 8'd0, 0, 0, 0);           // swap from origin
    add_row(dflt, 32'd65536, 8'd64, 8'd64, 0, 0, 0);     // source out of range
    add_row(dflt, 32'd12345, 8'd1, 8'd0, 0, 0, 0);       // source row not before
    add_row(dflt, 32'hFFFF_0000, 8'h80, 8'h7F, 0, 0, 0);
    // Zero temperature acts as one LSB; largest temperature with free edits.
    add_row(make_regs(1, 1, ONE_Q16, ONE_Q16, ONE_Q16, 0), 32'd0, 8'd0, 8'd0, 0, 0, 0);
    add_row(make_regs(1, 1, 0, 0, 0, CMAX), 32'h1234_5678, 8'd0, 8'd0, 0, 0, 0);
    // Widest costs at T = 1: a clipped edge read sets the flag.
    wide = make_regs(1, 2, CMAX, CMAX, CMAX, 1);
    add_row(wide, 32'd0, 8'hFF, 8'hFF, 0, 0, 0);
    add_row(wide, 32'h8000_0000, 8'hFF, 8'hFF, 1, 32'hFFFF_FFFF, 1);
    add_row(make_regs(1, 1, CMAX, CMAX, CMAX, 1), 32'h7FFF_FFFF, 8'hFF, 8'hFF,
            1, 32'h7FFF_FFFF, 0);
    // 2x2 with widest costs: cell values clip high; swap from (1,1) at the end.
    wide = make_regs(2, 2, CMAX, CMAX, CMAX, ONE_Q16);
    add_row(wide, 32'h7FFF_FFFF, 8'hFF, 8'hFF, 0, 0, 0);
    add_row(wide, 32'h7FFF_FFFF, 8'd0, 8'd0, 0, 0, 0);
    add_row(wide, 32'h7FFF_FFFF, 8'd0, 8'd1, 0, 0, 0);
    add_row(wide, 32'h7FFF_FFFF, 8'd1, 8'd1, 0, 0, 0);
    // Zero lengths act as one.
    add_row(make_regs(0, 0, 3 * ONE_Q16, ONE_Q16 / 2, 0, ONE_Q16 / 4),
            32'hFFFF_FFFF, 8'd0, 8'd0, 0, 0, 0);
    // 2x2 with cheap edits, swap sources all over.
    regs = make_regs(2, 2, ONE_Q16, ONE_Q16, ONE_Q16 / 2, ONE_Q16);
    add_row(regs, 32'd0, 8'd0, 8'd0, 0, 0, 0);
    add_row(regs, 32'd65536, 8'd0, 8'd0, 0, 0, 0);
    add_row(regs, 32'd65536, 8'd1, 8'd0, 0, 0, 0);
    add_row(regs, 32'd0, 8'd1, 8'd1, 0, 0, 0);

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.regs != cur_regs || k == 0) begin
        drain();
        load_regs(row.regs);
      end
      if (row.typed) begin
        // Score the cell for the state, then hold the typed value instead.
        send_cell(row.beat);
        void'(expected_scores.pop_back());
        expected_scores.push_back(row.score);
      end else begin
        send_cell(row.beat);
      end
    end

    // Random phases: a register set, then a few whole pairs of random cells.
    while (cells_sent < RANDOM_N + directed_rows.size()) begin
      drain();
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 4))
          0: begin la = 64;  lb = 1;  end
          1: begin la = 1;   lb = 64; end
          2: begin la = 127; lb = 1;  end
          3: begin la = 0;   lb = 64; end
          default: begin la = 2; lb = 33; end
        endcase
        npairs = 1;
      end else begin
        la     = $urandom_range(1, 4);
        lb     = $urandom_range(1, 4);
        npairs = $urandom_range(1, 4);
      end
      load_regs(make_regs(la, lb, pick_cost(), pick_cost(), pick_cost(), pick_temp()));
      for (int p = 0; p < npairs; p++)
        for (int i = 1; i <= clamp_len(la); i++)
          for (int j = 1; j <= clamp_len(lb); j++) begin
            if (cells_sent > RANDOM_N + directed_rows.size() - 60) quiet = 1'b1;
            send_cell(random_cell(i, j));
          end
    end

    // Let the last scores come out, then settle.
    in_valid <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d cells, %0d scores checked, %0d register writes",
             cells_sent, scores_checked, reg_writes);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches found", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #20_000_000;
    $display("timeout with %0d scores still pending", expected_scores.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
hdl/sdd_pkg.sv
hdl/sdd_mul.sv
hdl/sdd_div.sv
hdl/soft_damerau_edit_distance_top.sv
verif/tb_soft_damerau_edit_distance_top.sv
